### hw/rtl/ysend_pkg.sv
// Shared types, character codes and the CRC-16 byte step of the YMODEM sender.
package ysend_pkg;

   localparam int LongBlock  = 1024;
   localparam int ShortBlock = 128;
   localparam int AddrW      = $clog2(LongBlock);
   localparam int CountW     = AddrW + 1;

   localparam logic [7:0] ChSoh = 8'h01;
   localparam logic [7:0] ChStx = 8'h02;
   localparam logic [7:0] ChEot = 8'h04;
   localparam logic [7:0] ChAck = 8'h06;
   localparam logic [7:0] ChNak = 8'h15;
   localparam logic [7:0] ChCan = 8'h18;
   localparam logic [7:0] ChC   = 8'h43;

   localparam logic [15:0] CrcPoly = 16'h1021;

   typedef enum logic [3:0] {
      PH_IDLE      = 4'd0,
      PH_WAITC     = 4'd1,
      PH_COLLECT   = 4'd2,
      PH_SEND      = 4'd3,
      PH_WAITACK   = 4'd4,
      PH_EOT1      = 4'd5,
      PH_EOT2      = 4'd6,
      PH_WAITC_END = 4'd7,
      PH_DONE      = 4'd8,
      PH_ERROR     = 4'd9
   } phase_type;

   typedef enum logic [2:0] {
      K_LOAD   = 3'd0,
      K_CHAR   = 3'd1,
      K_TICK   = 3'd2,
      K_PULL   = 3'd3,
      K_START  = 3'd4,
      K_FINISH = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      REG_ACK_TIMEOUT  = 2'd0,
      REG_SEND_ATT     = 2'd1,
      REG_START_WAIT   = 2'd2,
      REG_START_ATT    = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] payload_byte;
      logic       last_of_write;
      logic [7:0] received_char;
   } item_type;

   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic [3:0] phase;
      logic       can_accept;
      logic       failed;
   } result_type;

   typedef struct packed {
      logic [15:0] ack_timeout_ticks;
      logic [3:0]  send_attempts;
      logic [15:0] start_wait_ticks;
      logic [3:0]  start_attempts;
   } cfg_type;

   typedef struct packed {
      logic             we;
      logic [AddrW-1:0] waddr;
      logic [7:0]       wdata;
      logic [AddrW-1:0] raddr;
   } mem_req_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) c = {c[14:0], 1'b0} ^ CrcPoly;
         else c = {c[14:0], 1'b0};
      end
      return c;
   endfunction

endpackage

### hw/rtl/ymodem_sender_engine_core.sv
// YMODEM sender top level: input register, settings registers and result register.
// An accepted item waits in the input register until the result register is free;
// its result is then written there. Throughput: one item per cycle while the
// response side does not stall; the packet store is read one item ahead.
// The result register frees for the next item in the cycle it is taken.
// Reset is synchronous and active high; it clears the settings to their defaults
// and the state to idle; the packet store holds no reset value.
module ymodem_sender_engine_core
   import ysend_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_kind,
   input  logic [7:0]  req_payload_byte,
   input  logic        req_last_of_write,
   input  logic [7:0]  req_received_char,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_tx_valid,
   output logic [7:0]  rsp_tx_byte,
   output logic [3:0]  rsp_phase,
   output logic        rsp_can_accept,
   output logic        rsp_failed,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   cfg_type     cfg_ff;
   logic        in_valid_ff;
   item_type    item_ff;
   logic        out_valid_ff;
   result_type  out_ff;
   logic        advance;
   logic        go;
   result_type  result;
   mem_req_type mem_req;
   logic [7:0]  rd_data;

   assign csr_ready = 1'b1;
   assign advance   = !out_valid_ff || !rsp_stall;
   assign go        = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ack_timeout_ticks <= 16'd5000;
         cfg_ff.send_attempts     <= 4'd3;
         cfg_ff.start_wait_ticks  <= 16'd1000;
         cfg_ff.start_attempts    <= 4'd10;
      end else if (csr_valid) begin
         unique case (reg_index_type'(csr_index))
            REG_ACK_TIMEOUT: cfg_ff.ack_timeout_ticks <= csr_data;
            REG_SEND_ATT:    cfg_ff.send_attempts     <= csr_data[3:0];
            REG_START_WAIT:  cfg_ff.start_wait_ticks  <= csr_data;
            REG_START_ATT:   cfg_ff.start_attempts    <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (!req_stall) in_valid_ff <= req_valid;
         if (advance) out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         item_ff.kind          <= req_kind;
         item_ff.payload_byte  <= req_payload_byte;
         item_ff.last_of_write <= req_last_of_write;
         item_ff.received_char <= req_received_char;
      end
      if (go) out_ff <= result;
   end

   ysend_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .go      (go),
      .item    (item_ff),
      .cfg     (cfg_ff),
      .rd_data (rd_data),
      .mem_req (mem_req),
      .result  (result)
   );

   ysend_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   assign rsp_valid      = out_valid_ff;
   assign rsp_tx_valid   = out_ff.tx_valid;
   assign rsp_tx_byte    = out_ff.tx_byte;
   assign rsp_phase      = out_ff.phase;
   assign rsp_can_accept = out_ff.can_accept;
   assign rsp_failed     = out_ff.failed;

endmodule

### hw/rtl/ysend_store.sv
// Packet store: one write port and one registered read port with write bypass.
module ysend_store
   import ysend_pkg::*;
(
   input  logic        clock,
   input  mem_req_type mem_req,
   output logic [7:0]  rd_data
);

   logic [7:0] mem [LongBlock];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) mem[mem_req.waddr] <= mem_req.wdata;
   end

   always_ff @(posedge clock) begin
      if (mem_req.we && mem_req.waddr == mem_req.raddr) rd_data_ff <= mem_req.wdata;
      else rd_data_ff <= mem[mem_req.raddr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/ysend_ctrl.sv
// Protocol state machine: applies one item to the sender state and forms its result.
module ysend_ctrl
   import ysend_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  item_type    item,
   input  cfg_type     cfg,
   input  logic [7:0]  rd_data,
   output mem_req_type mem_req,
   output result_type  result
);

   phase_type         phase_ff, phase_in;
   logic [CountW-1:0] fill_ff, fill_in;
   logic              long_ff, long_in;
   logic [7:0]        seq_ff, seq_in;
   logic [3:0]        att_ff, att_in;
   logic [15:0]       timer_ff, timer_in;
   logic [CountW-1:0] txpos_ff, txpos_in;
   logic [15:0]       crc_ff, crc_in;
   logic              closing_ff, closing_in;
   logic              opening_ff, opening_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         fill_ff    <= '0;
         long_ff    <= 1'b0;
         seq_ff     <= 8'd1;
         att_ff     <= '0;
         timer_ff   <= '0;
         txpos_ff   <= '0;
         crc_ff     <= '0;
         closing_ff <= 1'b0;
         opening_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         fill_ff    <= fill_in;
         long_ff    <= long_in;
         seq_ff     <= seq_in;
         att_ff     <= att_in;
         timer_ff   <= timer_in;
         txpos_ff   <= txpos_in;
         crc_ff     <= crc_in;
         closing_ff <= closing_in;
         opening_ff <= opening_in;
      end
   end

   logic              waiting;
   logic              fail;
   logic              txv;
   logic [7:0]        txb;
   logic [CountW-1:0] fc;
   logic [CountW-1:0] len;
   logic [7:0]        seq;
   logic [CountW-1:0] k;
   logic [7:0]        d;

   always_comb begin
      phase_in   = phase_ff;
      fill_in    = fill_ff;
      long_in    = long_ff;
      seq_in     = seq_ff;
      att_in     = att_ff;
      timer_in   = timer_ff;
      txpos_in   = txpos_ff;
      crc_in     = crc_ff;
      closing_in = closing_ff;
      opening_in = opening_ff;
      mem_req.we    = 1'b0;
      mem_req.waddr = fill_ff[AddrW-1:0];
      mem_req.wdata = item.payload_byte;
      fail = 1'b0;
      txv  = 1'b0;
      txb  = 8'h00;
      fc   = fill_ff;
      len  = long_ff ? CountW'(LongBlock) : CountW'(ShortBlock);
      seq  = (opening_ff || closing_ff) ? 8'h00 : seq_ff;
      k    = txpos_ff - CountW'(3);
      d    = (k < fill_ff) ? rd_data : 8'h00;
      waiting = phase_ff == PH_WAITC || phase_ff == PH_WAITACK || phase_ff == PH_WAITC_END
             || ((phase_ff == PH_EOT1 || phase_ff == PH_EOT2) && txpos_ff != '0);

      if (go) begin
         case (item.kind)
            K_LOAD: begin
               if (phase_ff == PH_IDLE) begin
                  if (fill_ff < CountW'(ShortBlock)) begin
                     mem_req.we = 1'b1;
                     fill_in = fill_ff + 1'b1;
                  end
               end else if (phase_ff == PH_COLLECT) begin
                  if (fill_ff < CountW'(LongBlock)) begin
                     mem_req.we = 1'b1;
                     fc = fill_ff + 1'b1;
                  end
                  fill_in = fc;
                  if (fc >= CountW'(LongBlock) || item.last_of_write) begin
                     long_in  = fc >= CountW'(ShortBlock);
                     phase_in = PH_SEND;
                     txpos_in = '0;
                     crc_in   = '0;
                     att_in   = cfg.send_attempts;
                  end
               end
            end
            K_CHAR: begin
               if (waiting) begin
                  if (item.received_char == ChCan) begin
                     fail = 1'b1;
                  end else begin
                     case (phase_ff)
                        PH_WAITC: begin
                           if (item.received_char == ChC) begin
                              phase_in = PH_SEND;
                              txpos_in = '0;
                              crc_in   = '0;
                              att_in   = cfg.send_attempts;
                           end
                        end
                        PH_WAITACK: begin
                           if (item.received_char == ChAck) begin
                              if (closing_ff) begin
                                 phase_in = PH_DONE;
                              end else begin
                                 if (!opening_ff) seq_in = seq_ff + 8'd1;
                                 opening_in = 1'b0;
                                 phase_in   = PH_COLLECT;
                              end
                              fill_in = '0;
                              long_in = 1'b0;
                           end
                        end
                        PH_EOT1: begin
                           if (item.received_char == ChNak) begin
                              phase_in = PH_EOT2;
                              txpos_in = '0;
                           end
                        end
                        PH_EOT2: begin
                           if (item.received_char == ChAck) begin
                              phase_in = PH_WAITC_END;
                              timer_in = cfg.ack_timeout_ticks;
                           end
                        end
                        default: begin
                           if (item.received_char == ChC) begin
                              closing_in = 1'b1;
                              opening_in = 1'b0;
                              long_in    = 1'b0;
                              fill_in    = '0;
                              phase_in   = PH_SEND;
                              txpos_in   = '0;
                              crc_in     = '0;
                              att_in     = cfg.send_attempts;
                           end
                        end
                     endcase
                  end
               end
            end
            K_TICK: begin
               if (waiting) begin
                  if (timer_ff <= 16'd1) begin
                     timer_in = '0;
                     fail = 1'b1;
                  end else begin
                     timer_in = timer_ff - 16'd1;
                  end
               end
            end
            K_PULL: begin
               if (phase_ff == PH_EOT1 || phase_ff == PH_EOT2) begin
                  if (txpos_ff == '0) begin
                     txpos_in = CountW'(1);
                     timer_in = cfg.ack_timeout_ticks;
                     txv = 1'b1;
                     txb = ChEot;
                  end
               end else if (phase_ff == PH_SEND) begin
                  txv = 1'b1;
                  txpos_in = txpos_ff + 1'b1;
                  if (txpos_ff == CountW'(0)) begin
                     txb = long_ff ? ChStx : ChSoh;
                  end else if (txpos_ff == CountW'(1)) begin
                     txb = seq;
                  end else if (txpos_ff == CountW'(2)) begin
                     txb = 8'hFF - seq;
                  end else if (txpos_ff < len + CountW'(3)) begin
                     crc_in = crc_byte(crc_ff, d);
                     txb = d;
                  end else if (txpos_ff == len + CountW'(3)) begin
                     txb = crc_ff[15:8];
                  end else begin
                     txb = crc_ff[7:0];
                     txpos_in = txpos_ff;
                     phase_in = PH_WAITACK;
                     timer_in = cfg.ack_timeout_ticks;
                  end
               end
            end
            K_START: begin
               if (phase_ff == PH_IDLE) begin
                  phase_in   = PH_WAITC;
                  att_in     = cfg.start_attempts;
                  timer_in   = cfg.start_wait_ticks;
                  opening_in = 1'b1;
                  closing_in = 1'b0;
                  long_in    = 1'b0;
                  seq_in     = 8'd1;
               end
            end
            K_FINISH: begin
               if (phase_ff == PH_COLLECT && fill_ff == '0) begin
                  phase_in = PH_EOT1;
                  txpos_in = '0;
               end
            end
            default: ;
         endcase
      end

      // Timeout/CAN: C, ACK waits retry while tries last, EOT1 to EOT2, else error.
      if (fail) begin
         unique case (phase_ff)
            PH_WAITC: begin
               if (att_ff <= 4'd1) begin
                  att_in = '0;
                  phase_in = PH_ERROR;
               end else begin
                  att_in = att_ff - 4'd1;
                  timer_in = cfg.start_wait_ticks;
               end
            end
            PH_WAITACK: begin
               if (att_ff <= 4'd1) begin
                  att_in = '0;
                  phase_in = PH_ERROR;
               end else begin
                  att_in   = att_ff - 4'd1;
                  phase_in = PH_SEND;
                  txpos_in = '0;
                  crc_in   = '0;
               end
            end
            PH_EOT1: begin
               phase_in = PH_EOT2;
               txpos_in = '0;
            end
            default: phase_in = PH_ERROR;
         endcase
      end

      // The store is read ahead at the data position that the next pull will use.
      mem_req.raddr = txpos_in[AddrW-1:0] - AddrW'(3);

      result.tx_valid   = txv;
      result.tx_byte    = txb;
      result.phase      = phase_in;
      result.can_accept = (phase_in == PH_IDLE && fill_in < CountW'(ShortBlock))
                       || phase_in == PH_COLLECT;
      result.failed     = phase_in == PH_ERROR;
   end

endmodule
